// ----- rtl/core/rtcas_pkg.sv -----
// Shared types and constants for the real-time clock peripheral.
// Used by rtcas_time_calc and rtc_alarm_stopwatch_peripheral; no dependencies.
`default_nettype none

package rtcas_pkg;

   // time of day in register layout: [31:17] day, [16:12] hour, [11:6] min, [5:0] sec
   typedef struct packed {
      logic [14:0] day;
      logic [4:0]  hour;
      logic [5:0]  min;
      logic [5:0]  sec;
   } time_type;

   // item commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // register words
   localparam logic [2:0] REG_TIME      = 3'd0;
   localparam logic [2:0] REG_ENABLES   = 3'd1;
   localparam logic [2:0] REG_STATUS    = 3'd2;
   localparam logic [2:0] REG_STOPWATCH = 3'd3;
   localparam logic [2:0] REG_ALARM     = 3'd4;
   localparam logic [2:0] REG_PRESCALER = 3'd5;

   // internal event flag bits
   localparam int EV_STOPWATCH = 0;
   localparam int EV_ALARM     = 1;
   localparam int EV_SEC       = 2;
   localparam int EV_MIN       = 3;
   localparam int EV_HOUR      = 4;
   localparam int EV_DAY       = 5;
   localparam int EV_DAY_ALARM = 6;
   localparam int EV_WR_DONE   = 7;

   // status/enables word bit positions on the bus
   localparam int BUS_WR_PENDING = 14;
   localparam int BUS_WR_DONE    = 15;

   // field limits
   localparam logic [6:0] SEC_PER_MIN  = 7'd60;
   localparam logic [6:0] MIN_PER_HOUR = 7'd60;
   localparam logic [5:0] HOUR_PER_DAY = 6'd24;

endpackage : rtcas_pkg

`default_nettype wire

// ----- rtl/core/rtcas_time_calc.sv -----
// Time arithmetic: one-second advance of the current time and normalization
// of a written time word. Depends on rtcas_pkg.
`default_nettype none

module rtcas_time_calc (
   input  wire rtcas_pkg::time_type cur_time,
   input  wire rtcas_pkg::time_type wr_time,
   output rtcas_pkg::time_type      adv_time,
   output rtcas_pkg::time_type      norm_time
);

   logic [6:0] adv_sec_sum;
   logic [6:0] adv_min_sum;
   logic [5:0] adv_hour_sum;
   logic       adv_c1;
   logic       adv_c2;
   logic       adv_c3;

   logic       nrm_c1;
   logic       nrm_c2;
   logic       nrm_c3;
   logic [6:0] nrm_sec;
   logic [6:0] nrm_min_sum;
   logic [6:0] nrm_min;
   logic [5:0] nrm_hour_sum;
   logic [5:0] nrm_hour;

   // advance by one second: sec, min and hour wrap to zero and carry, day counts up
   always_comb begin
      adv_sec_sum  = {1'b0, cur_time.sec} + 7'd1;
      adv_c1       = (adv_sec_sum >= rtcas_pkg::SEC_PER_MIN);
      adv_min_sum  = {1'b0, cur_time.min} + {6'd0, adv_c1};
      adv_c2       = (adv_min_sum >= rtcas_pkg::MIN_PER_HOUR);
      adv_hour_sum = {1'b0, cur_time.hour} + {5'd0, adv_c2};
      adv_c3       = (adv_hour_sum >= rtcas_pkg::HOUR_PER_DAY);

      adv_time.sec  = adv_c1 ? 6'd0 : adv_sec_sum[5:0];
      adv_time.min  = adv_c2 ? 6'd0 : adv_min_sum[5:0];
      adv_time.hour = adv_c3 ? 5'd0 : adv_hour_sum[4:0];
      adv_time.day  = cur_time.day + {14'd0, adv_c3};
   end

   // normalize a written time: each field is below twice its radix once the
   // carry from below is added, so one compare and subtract per field
   always_comb begin
      nrm_c1       = ({1'b0, wr_time.sec} >= rtcas_pkg::SEC_PER_MIN);
      nrm_sec      = nrm_c1 ? ({1'b0, wr_time.sec} - rtcas_pkg::SEC_PER_MIN)
                            : {1'b0, wr_time.sec};
      nrm_min_sum  = {1'b0, wr_time.min} + {6'd0, nrm_c1};
      nrm_c2       = (nrm_min_sum >= rtcas_pkg::MIN_PER_HOUR);
      nrm_min      = nrm_c2 ? (nrm_min_sum - rtcas_pkg::MIN_PER_HOUR) : nrm_min_sum;
      nrm_hour_sum = {1'b0, wr_time.hour} + {5'd0, nrm_c2};
      nrm_c3       = (nrm_hour_sum >= rtcas_pkg::HOUR_PER_DAY);
      nrm_hour     = nrm_c3 ? (nrm_hour_sum - rtcas_pkg::HOUR_PER_DAY) : nrm_hour_sum;

      norm_time.sec  = nrm_sec[5:0];
      norm_time.min  = nrm_min[5:0];
      norm_time.hour = nrm_hour[4:0];
      norm_time.day  = wr_time.day + {14'd0, nrm_c3};
   end

endmodule : rtcas_time_calc

`default_nettype wire

// ----- rtl/core/rtc_alarm_stopwatch_peripheral.sv -----
// Real-time clock with alarm and stopwatch: top level with register file,
// tick logic and handshakes. Depends on rtcas_pkg and rtcas_time_calc.
//
// Usage:
//   The req_ channel carries one item per handshake: a bus read, a bus write
//   or a tick (req_cmd), with the register word, write data and the
//   second-elapsed flag. Every item gives exactly one rsp_ item: read data
//   (zero for writes and ticks) and the interrupt line as last updated by a
//   tick.
//   An accepted item is held in the input register and is worked once the
//   output register is empty or its result is being taken; the result is
//   then registered in the output register, which drives rsp_valid. One item
//   per cycle is sustained while rsp_ready stays high, since each item is
//   a single pass of counter and compare logic.
//   If rsp_ready stays low, the output register holds its result and one more
//   item is taken into the input register; req_ready then drops until the
//   result is taken.
//   Synchronous reset clears the time, enables, status, stopwatch, alarm,
//   prescaler enable, interrupt line and the valid flags of both register stages.
`default_nettype none

module rtc_alarm_stopwatch_peripheral (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_cmd,
   input  wire  [2:0]  req_reg_index,
   input  wire  [31:0] req_write_data,
   input  wire         req_second_elapsed,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq
);

   // input register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [1:0]  s1_cmd_ff;
   logic [2:0]  s1_reg_ff;
   logic [31:0] s1_data_ff;
   logic        s1_second_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;

   // block state
   rtcas_pkg::time_type time_ff;
   rtcas_pkg::time_type time_in;
   logic [7:0]  enables_ff;
   logic [7:0]  enables_in;
   logic [7:0]  flags_ff;
   logic [7:0]  flags_in;
   logic        pending_ff;
   logic        pending_in;
   logic [15:0] stopwatch_ff;
   logic [15:0] stopwatch_in;
   logic [31:0] alarm_ff;
   logic [31:0] alarm_in;
   logic        prescaler_ff;
   logic        prescaler_in;
   logic        irq_ff;
   logic        irq_in;

   logic        advance;
   logic        work;
   logic        accept;

   rtcas_pkg::time_type adv_time;
   rtcas_pkg::time_type norm_time;
   rtcas_pkg::time_type alarm_time;

   // handshake: the output register empties or is taken, so the item moves on
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign work      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq       = irq_ff;

   assign alarm_time = rtcas_pkg::time_type'(alarm_ff);

   rtcas_time_calc u_time_calc (
      .cur_time  (time_ff),
      .wr_time   (rtcas_pkg::time_type'(s1_data_ff)),
      .adv_time  (adv_time),
      .norm_time (norm_time)
   );

   // input register control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (work) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // item processing: register reads, writes and tick updates
   always_comb begin
      time_in      = time_ff;
      enables_in   = enables_ff;
      flags_in     = flags_ff;
      pending_in   = pending_ff;
      stopwatch_in = stopwatch_ff;
      alarm_in     = alarm_ff;
      prescaler_in = prescaler_ff;
      irq_in       = irq_ff;
      rsp_data_in  = 32'd0;

      unique case (s1_cmd_ff)
         rtcas_pkg::CMD_READ: begin
            unique case (s1_reg_ff)
               rtcas_pkg::REG_TIME:      rsp_data_in = time_ff;
               rtcas_pkg::REG_ENABLES: begin
                  rsp_data_in[6:0]                   = enables_ff[6:0];
                  rsp_data_in[rtcas_pkg::BUS_WR_DONE] = enables_ff[rtcas_pkg::EV_WR_DONE];
               end
               rtcas_pkg::REG_STATUS: begin
                  rsp_data_in[6:0]                      = flags_ff[6:0];
                  rsp_data_in[rtcas_pkg::BUS_WR_PENDING] = pending_ff;
                  rsp_data_in[rtcas_pkg::BUS_WR_DONE]    = flags_ff[rtcas_pkg::EV_WR_DONE];
               end
               rtcas_pkg::REG_STOPWATCH: rsp_data_in = {16'd0, stopwatch_ff};
               rtcas_pkg::REG_ALARM:     rsp_data_in = alarm_ff;
               rtcas_pkg::REG_PRESCALER: rsp_data_in = {31'd0, prescaler_ff};
               default:                  rsp_data_in = 32'd0;
            endcase
         end
         rtcas_pkg::CMD_WRITE: begin
            unique case (s1_reg_ff)
               rtcas_pkg::REG_TIME: begin
                  pending_in = 1'b1;
                  time_in    = norm_time;
               end
               rtcas_pkg::REG_ENABLES: begin
                  enables_in = {s1_data_ff[rtcas_pkg::BUS_WR_DONE], s1_data_ff[6:0]};
               end
               rtcas_pkg::REG_STATUS: begin
                  flags_in = flags_ff &
                             ~{s1_data_ff[rtcas_pkg::BUS_WR_DONE], s1_data_ff[6:0]};
               end
               rtcas_pkg::REG_STOPWATCH: begin
                  pending_in   = 1'b1;
                  stopwatch_in = s1_data_ff[15:0];
               end
               rtcas_pkg::REG_ALARM: begin
                  pending_in = 1'b1;
                  alarm_in   = s1_data_ff;
               end
               rtcas_pkg::REG_PRESCALER: begin
                  pending_in   = 1'b1;
                  prescaler_in = s1_data_ff[0];
               end
               default: begin
               end
            endcase
         end
         rtcas_pkg::CMD_TICK: begin
            // pending write completes on any tick
            if (pending_ff) begin
               pending_in                      = 1'b0;
               flags_in[rtcas_pkg::EV_WR_DONE] = 1'b1;
            end
            if (s1_second_ff) begin
               time_in = adv_time;
               if (prescaler_ff) begin
                  flags_in[rtcas_pkg::EV_SEC] = 1'b1;
                  if (adv_time.sec == 6'd0) begin
                     flags_in[rtcas_pkg::EV_MIN] = 1'b1;
                     if (adv_time.min == 6'd0) begin
                        flags_in[rtcas_pkg::EV_HOUR] = 1'b1;
                        if (adv_time.hour == 5'd0) begin
                           flags_in[rtcas_pkg::EV_DAY] = 1'b1;
                        end
                     end
                  end
                  // alarm match on hour:min:sec, day alarm adds the day
                  if (alarm_ff != 32'd0 && alarm_time.sec == adv_time.sec &&
                      alarm_time.min == adv_time.min &&
                      alarm_time.hour == adv_time.hour) begin
                     flags_in[rtcas_pkg::EV_ALARM] = 1'b1;
                     if (alarm_time.day == adv_time.day) begin
                        flags_in[rtcas_pkg::EV_DAY_ALARM] = 1'b1;
                     end
                  end
                  // stopwatch countdown
                  if (stopwatch_ff != 16'd0) begin
                     stopwatch_in = stopwatch_ff - 16'd1;
                     if (stopwatch_ff == 16'd1) begin
                        flags_in[rtcas_pkg::EV_STOPWATCH] = 1'b1;
                     end
                  end
               end
            end
            irq_in = |(enables_ff & flags_in);
         end
         default: begin
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         enables_ff   <= 8'd0;
         flags_ff     <= 8'd0;
         pending_ff   <= 1'b0;
         stopwatch_ff <= 16'd0;
         alarm_ff     <= 32'd0;
         prescaler_ff <= 1'b0;
         irq_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work) begin
            time_ff      <= time_in;
            enables_ff   <= enables_in;
            flags_ff     <= flags_in;
            pending_ff   <= pending_in;
            stopwatch_ff <= stopwatch_in;
            alarm_ff     <= alarm_in;
            prescaler_ff <= prescaler_in;
            irq_ff       <= irq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_reg_ff    <= req_reg_index;
         s1_data_ff   <= req_write_data;
         s1_second_ff <= req_second_elapsed;
      end
      if (work) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // time fields stay within their radix
   assert property (@(posedge clock) disable iff (reset)
      time_ff.sec < 6'd60 && time_ff.min < 6'd60 && time_ff.hour < 5'd24)
      else $error("time field out of range");

   // interrupt line moves only on ticks
   assert property (@(posedge clock) disable iff (reset)
      !(work && s1_cmd_ff == rtcas_pkg::CMD_TICK) |=> $stable(irq_ff))
      else $error("interrupt changed outside a tick");

   // a tick always retires a pending write
   assert property (@(posedge clock) disable iff (reset)
      work && s1_cmd_ff == rtcas_pkg::CMD_TICK |=> !pending_ff)
      else $error("write still pending after tick");

   // only reads return data
   assert property (@(posedge clock) disable iff (reset)
      work && s1_cmd_ff != rtcas_pkg::CMD_READ |=> rsp_data_ff == 32'd0)
      else $error("nonzero data for a non-read item");

   // input stalls only when both stages are full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without cause");

endmodule : rtc_alarm_stopwatch_peripheral

`default_nettype wire
